[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared sizes, codes and controller/datapath interface types of the pool.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int SLOTS      = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int TREE_N     = 1 << SLOT_W;
	localparam int CAP_W      = 5;
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int FILE_W     = 8;
	localparam int BLOCK_W    = 16;
	localparam int OUT_SLOT_W = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_ACCESS = 2'd0,
		CMD_PIN    = 2'd1,
		CMD_UNPIN  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		RES_HIT      = 3'd0,
		RES_LOAD     = 3'd1,
		RES_EVICT    = 3'd2,
		RES_OVERLOAD = 3'd3,
		RES_NOT_RES  = 3'd4,
		RES_DONE     = 3'd5
	} res_t;

	typedef enum logic [1:0] {
		FSM_IDLE   = 2'd0,
		FSM_EVAL   = 2'd1,
		FSM_COMMIT = 2'd2
	} fsm_t;

	typedef struct packed {
		logic capture;  // load request registers
		logic eval;     // register lookup, free slot and victim search
		logic commit;   // update pool state and load result register
	} dp_ctl_t;

	typedef struct packed {
		logic out_free; // result register can take a new beat
	} dp_sts_t;

endpackage

[sv/lbp_ctrl.sv]
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: capture a request, evaluate it, commit it when the result
// register is free.
// ----------------------------------------------------------------------------
module lbp_ctrl import lbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_ctl_t ctl
);

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.capture = 1'b0;
		ctl.eval    = 1'b0;
		ctl.commit  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = FSM_EVAL;
				end
			end
			FSM_EVAL: begin
				ctl.eval = 1'b1;
				state_d  = FSM_COMMIT;
			end
			FSM_COMMIT: begin
				// hold until the previous result beat has left
				if (sts.out_free) begin
					ctl.commit = 1'b1;
					in_ready   = 1'b1;
					if (in_valid) begin
						ctl.capture = 1'b1;
						state_d     = FSM_EVAL;
					end else begin
						state_d = FSM_IDLE;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

[sv/lbp_dpath.sv]
// ----------------------------------------------------------------------------
// lbp_dpath
// Tag store, pin and recency state, lookup and victim search, result register.
// ----------------------------------------------------------------------------
module lbp_dpath import lbp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_ctl_t               ctl,
	output dp_sts_t               sts,
	input  logic [1:0]            in_cmd,
	input  logic [FILE_W-1:0]     in_file,
	input  logic [BLOCK_W-1:0]    in_block,
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            out_status,
	output logic [OUT_SLOT_W-1:0] out_slot,
	output logic                  out_ev,
	output logic [FILE_W-1:0]     out_ef,
	output logic [BLOCK_W-1:0]    out_eb
);

	// configuration
	logic [CAP_W-1:0] capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// request registers
	cmd_t               req_cmd_q;
	logic [FILE_W-1:0]  req_file_q;
	logic [BLOCK_W-1:0] req_block_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_cmd_q   <= cmd_t'(in_cmd);
			req_file_q  <= in_file;
			req_block_q <= in_block;
		end
	end

	// pool state
	logic [SLOTS-1:0]   valid_q;
	logic [SLOTS-1:0]   pinned_q;
	logic [CNT_W-1:0]   used_q;
	logic [FILE_W-1:0]  tag_file_q  [SLOTS];
	logic [BLOCK_W-1:0] tag_block_q [SLOTS];
	logic [SLOT_W-1:0]  rank_q      [SLOTS];

	// lookup, free slot and room
	logic [SLOTS-1:0]  hit_vec;
	logic              hit_any;
	logic [SLOT_W-1:0] hit_idx;
	logic [SLOT_W-1:0] hit_rank;
	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	logic              room;

	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		hit_rank = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && (tag_file_q[i] == req_file_q)
				&& (tag_block_q[i] == req_block_q);
			hit_any  = hit_any | hit_vec[i];
			hit_rank = hit_rank | (hit_vec[i] ? rank_q[i] : '0);
			free_any = free_any | ~valid_q[i];
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		if (capacity_q == '0) begin
			room = (used_q == '0);
		end else begin
			room = (CMP_W'(used_q) < CMP_W'(capacity_q))
				&& (used_q < CNT_W'(SLOTS));
		end
	end

	// victim search: least recent unpinned entry, as a pairwise tree
	logic              vt_ok  [SLOT_W+1][TREE_N];
	logic [SLOT_W-1:0] vt_idx [SLOT_W+1][TREE_N];
	logic [SLOT_W-1:0] vt_rk  [SLOT_W+1][TREE_N];

	always_comb begin
		for (int l = 0; l <= SLOT_W; l++) begin
			for (int n = 0; n < TREE_N; n++) begin
				vt_ok[l][n]  = 1'b0;
				vt_idx[l][n] = '0;
				vt_rk[l][n]  = '0;
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			vt_ok[0][i]  = valid_q[i] & ~pinned_q[i];
			vt_idx[0][i] = SLOT_W'(i);
			vt_rk[0][i]  = rank_q[i];
		end
		for (int l = 0; l < SLOT_W; l++) begin
			for (int n = 0; n < (TREE_N >> (l + 1)); n++) begin
				if (vt_ok[l][2*n+1] && (!vt_ok[l][2*n] || vt_rk[l][2*n+1] > vt_rk[l][2*n])) begin
					vt_ok[l+1][n]  = 1'b1;
					vt_idx[l+1][n] = vt_idx[l][2*n+1];
					vt_rk[l+1][n]  = vt_rk[l][2*n+1];
				end else begin
					vt_ok[l+1][n]  = vt_ok[l][2*n];
					vt_idx[l+1][n] = vt_idx[l][2*n];
					vt_rk[l+1][n]  = vt_rk[l][2*n];
				end
			end
		end
	end

	// evaluation registers
	logic [SLOTS-1:0]  hit_vec_s1;
	logic              hit_any_s1;
	logic [SLOT_W-1:0] hit_idx_s1;
	logic [SLOT_W-1:0] hit_rank_s1;
	logic              free_ok_s1;
	logic [SLOT_W-1:0] free_idx_s1;
	logic              vic_ok_s1;
	logic [SLOT_W-1:0] vic_idx_s1;
	logic [SLOT_W-1:0] vic_rank_s1;

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			hit_vec_s1  <= hit_vec;
			hit_any_s1  <= hit_any;
			hit_idx_s1  <= hit_idx;
			hit_rank_s1 <= hit_rank;
			free_ok_s1  <= room & free_any;
			free_idx_s1 <= free_idx;
			vic_ok_s1   <= vt_ok[SLOT_W][0];
			vic_idx_s1  <= vt_idx[SLOT_W][0];
			vic_rank_s1 <= vt_rk[SLOT_W][0];
		end
	end

	// commit decisions
	logic              do_clear, do_pin, do_unpin, do_touch, do_load, do_evict;
	logic [SLOT_W-1:0] ins_idx;
	res_t              res_status;
	logic [SLOT_W-1:0] res_slot;

	always_comb begin
		do_clear   = 1'b0;
		do_pin     = 1'b0;
		do_unpin   = 1'b0;
		do_touch   = 1'b0;
		do_load    = 1'b0;
		do_evict   = 1'b0;
		res_status = RES_DONE;
		res_slot   = '0;
		case (req_cmd_q)
			CMD_CLEAR: begin
				do_clear = 1'b1;
			end
			CMD_PIN, CMD_UNPIN: begin
				if (hit_any_s1) begin
					do_pin   = (req_cmd_q == CMD_PIN);
					do_unpin = (req_cmd_q == CMD_UNPIN);
					res_slot = hit_idx_s1;
				end else begin
					res_status = RES_NOT_RES;
				end
			end
			CMD_ACCESS: begin
				if (hit_any_s1) begin
					do_touch   = 1'b1;
					res_status = RES_HIT;
					res_slot   = hit_idx_s1;
				end else if (free_ok_s1) begin
					do_load    = 1'b1;
					res_status = RES_LOAD;
					res_slot   = free_idx_s1;
				end else if (vic_ok_s1) begin
					do_evict   = 1'b1;
					res_status = RES_EVICT;
					res_slot   = vic_idx_s1;
				end else begin
					res_status = RES_OVERLOAD;
				end
			end
			default: begin
				res_status = RES_DONE;
			end
		endcase
		ins_idx = do_load ? free_idx_s1 : vic_idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			pinned_q <= '0;
			used_q   <= '0;
		end else if (ctl.commit) begin
			if (do_clear) begin
				valid_q  <= '0;
				pinned_q <= '0;
				used_q   <= '0;
			end
			if (do_pin) begin
				pinned_q[hit_idx_s1] <= 1'b1;
			end
			if (do_unpin) begin
				pinned_q[hit_idx_s1] <= 1'b0;
			end
			if (do_load) begin
				valid_q[ins_idx]  <= 1'b1;
				pinned_q[ins_idx] <= 1'b0;
				used_q            <= used_q + CNT_W'(1);
			end
			if (do_evict) begin
				pinned_q[ins_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (valid_q[i]) begin
					if (do_touch) begin
						if (hit_vec_s1[i]) begin
							rank_q[i] <= '0;
						end else if (rank_q[i] < hit_rank_s1) begin
							rank_q[i] <= rank_q[i] + SLOT_W'(1);
						end
					end
					if (do_load) begin
						rank_q[i] <= rank_q[i] + SLOT_W'(1);
					end
					// victim leaves and re-enters: entries more recent than it age by one
					if (do_evict && rank_q[i] < vic_rank_s1) begin
						rank_q[i] <= rank_q[i] + SLOT_W'(1);
					end
				end
				if ((do_load || do_evict) && (SLOT_W'(i) == ins_idx)) begin
					rank_q[i]      <= '0;
					tag_file_q[i]  <= req_file_q;
					tag_block_q[i] <= req_block_q;
				end
			end
		end
	end

	// result register
	logic                  out_valid_q;
	res_t                  out_status_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;
	logic                  out_ev_q;
	logic [FILE_W-1:0]     out_ef_q;
	logic [BLOCK_W-1:0]    out_eb_q;
	logic [SLOT_W+OUT_SLOT_W-1:0] slot_wide;

	assign slot_wide    = {{OUT_SLOT_W{1'b0}}, res_slot};
	assign sts.out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_status_q <= res_status;
			out_slot_q   <= slot_wide[OUT_SLOT_W-1:0];
			out_ev_q     <= do_evict;
			out_ef_q     <= do_evict ? tag_file_q[vic_idx_s1] : '0;
			out_eb_q     <= do_evict ? tag_block_q[vic_idx_s1] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_ev     = out_ev_q;
	assign out_ef     = out_ef_q;
	assign out_eb     = out_eb_q;

endmodule

[sv/lru_buffer_pool_with_pins.sv]
// ----------------------------------------------------------------------------
// lru_buffer_pool_with_pins
// Fully associative LRU buffer pool directory with pin marks.
//
// Channel   Dir  Beat contents
// s_axis    in   tuser: cmd[1:0]; tdata: file_number, block_number
// m_axis    out  tuser: status[2:0]; tdata: slot, evicted_valid/file/block
// cfg       in   capacity[4:0], always ready
//
// Each request is captured, then evaluated (tag match, free slot and victim
// search tree registered), then committed (pool state updated and result
// register loaded). The next beat is taken in the commit cycle, not during
// evaluation. Reset empties the pool and sets capacity to 16 at once.
// A stalled result beat holds commit, and with it the input side.
// ----------------------------------------------------------------------------
module lru_buffer_pool_with_pins import lbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // file_number[7:0], block_number[23:8]
	input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // slot[3:0], evicted_valid[4],
	                                    // evicted_file[12:5], evicted_block[28:13]
	output logic [2:0]  m_axis_tuser,   // status[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data        // capacity[4:0]
);

	`include "assert_macros.svh"

	dp_ctl_t               ctl;
	dp_sts_t               sts;
	logic [OUT_SLOT_W-1:0] o_slot;
	logic                  o_ev;
	logic [FILE_W-1:0]     o_ef;
	logic [BLOCK_W-1:0]    o_eb;

	assign cfg_ready = 1'b1;

	lbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	lbp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_cmd     (s_axis_tuser),
		.in_file    (s_axis_tdata[7:0]),
		.in_block   (s_axis_tdata[23:8]),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_slot   (o_slot),
		.out_ev     (o_ev),
		.out_ef     (o_ef),
		.out_eb     (o_eb)
	);

	assign m_axis_tdata = {3'b000, o_eb, o_ef, o_ev, o_slot};

	`ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted during evaluation")
	`ASSERT_NEXT(a_commit_shows, ctl.commit, m_axis_tvalid, "committed result not presented")
	`ASSERT_SAME(a_evict_flag, m_axis_tvalid, m_axis_tdata[4] == (m_axis_tuser == RES_EVICT), "eviction flag disagrees with status")
	`ASSERT_ALWAYS(a_commit_free, !ctl.commit || sts.out_free, "commit into occupied result register")

endmodule

[tb/lru_pool_monitor.sv]
// ----------------------------------------------------------------------------
// lru_pool_monitor
// Watches the request, reply and capacity channels of the buffer pool, keeps
// its own copy of the pool directory, and compares every reply beat field by
// field with the oldest predicted reply. Reports the mismatch count and the
// number of replies still outstanding.
// ----------------------------------------------------------------------------
module lru_pool_monitor import lbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // file_number[7:0], block_number[23:8]
	input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // slot[3:0], evicted_valid[4],
	                                    // evicted_file[12:5], evicted_block[28:13]
	input  logic [2:0]  m_axis_tuser,   // status[2:0]
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [4:0]  cfg_data,       // capacity[4:0]
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		res_t                  status;
		logic [OUT_SLOT_W-1:0] slot;
		logic                  ev;
		logic [FILE_W-1:0]     ev_file;
		logic [BLOCK_W-1:0]    ev_block;
	} reply_t;

	logic [CAP_W-1:0]   capacity;
	logic               resident [SLOTS];
	logic               pin_mark [SLOTS];
	logic [FILE_W-1:0]  tag_f    [SLOTS];
	logic [BLOCK_W-1:0] tag_b    [SLOTS];
	int                 rank     [SLOTS];
	int                 occupancy;
	reply_t             expected_replies [$];

	function automatic int lookup(logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
		for (int i = 0; i < SLOTS; i++)
			if (resident[i] && tag_f[i] == f && tag_b[i] == b)
				return i;
		return -1;
	endfunction

	// New entry becomes most recent; every other entry ages by one.
	function automatic void place(int s, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
		for (int i = 0; i < SLOTS; i++)
			if (resident[i])
				rank[i]++;
		resident[s] = 1'b1;
		pin_mark[s] = 1'b0;
		tag_f[s] = f;
		tag_b[s] = b;
		rank[s] = 0;
		occupancy++;
	endfunction

	function automatic reply_t serve_request(cmd_t op, logic [FILE_W-1:0] f,
	                                         logic [BLOCK_W-1:0] b);
		reply_t r;
		int hit;
		int free_slot;
		int victim;
		int limit;
		int old;
		r = '0;
		r.status = RES_DONE;
		hit = lookup(f, b);
		case (op)
			CMD_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					resident[i] = 1'b0;
					pin_mark[i] = 1'b0;
				end
				occupancy = 0;
			end
			CMD_PIN, CMD_UNPIN: begin
				if (hit < 0) begin
					r.status = RES_NOT_RES;
				end else begin
					pin_mark[hit] = (op == CMD_PIN);
					r.slot = hit[OUT_SLOT_W-1:0];
				end
			end
			default: begin
				if (hit >= 0) begin
					old = rank[hit];
					for (int i = 0; i < SLOTS; i++)
						if (resident[i] && rank[i] < old)
							rank[i]++;
					rank[hit] = 0;
					r.status = RES_HIT;
					r.slot = hit[OUT_SLOT_W-1:0];
				end else begin
					limit = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
					free_slot = -1;
					if (occupancy < limit)
						for (int i = 0; i < SLOTS; i++)
							if (!resident[i] && free_slot < 0)
								free_slot = i;
					if (free_slot >= 0) begin
						place(free_slot, f, b);
						r.status = RES_LOAD;
						r.slot = free_slot[OUT_SLOT_W-1:0];
					end else begin
						// oldest unpinned entry goes; ties cannot occur among valid ranks
						victim = -1;
						for (int i = 0; i < SLOTS; i++)
							if (resident[i] && !pin_mark[i] && (victim < 0 || rank[i] > rank[victim]))
								victim = i;
						if (victim < 0) begin
							r.status = RES_OVERLOAD;
						end else begin
							r.ev = 1'b1;
							r.ev_file = tag_f[victim];
							r.ev_block = tag_b[victim];
							old = rank[victim];
							resident[victim] = 1'b0;
							for (int i = 0; i < SLOTS; i++)
								if (resident[i] && rank[i] > old)
									rank[i]--;
							occupancy--;
							place(victim, f, b);
							r.status = RES_EVICT;
							r.slot = victim[OUT_SLOT_W-1:0];
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			capacity = CAP_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				resident[i] = 1'b0;
				pin_mark[i] = 1'b0;
				tag_f[i] = '0;
				tag_b[i] = '0;
				rank[i] = 0;
			end
			occupancy = 0;
			expected_replies.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			// retire the reply beat before queueing a request taken on the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_replies.size() == 0) begin
					if (mismatches < 10)
						$display("%t: reply beat with none outstanding: status %0d tdata %h",
						         $realtime, m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (m_axis_tuser !== want.status || m_axis_tdata[3:0] !== want.slot ||
					    m_axis_tdata[4] !== want.ev || m_axis_tdata[12:5] !== want.ev_file ||
					    m_axis_tdata[28:13] !== want.ev_block) begin
						if (mismatches < 10) begin
							$display("%t: reply mismatch: expected status %0d slot %0d ev %0b file %h block %h",
							         $realtime, want.status, want.slot, want.ev,
							         want.ev_file, want.ev_block);
							$display("%t: reply mismatch: got status %0d slot %0d ev %0b file %h block %h",
							         $realtime, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[4],
							         m_axis_tdata[12:5], m_axis_tdata[28:13]);
						end
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_replies.push_back(serve_request(cmd_t'(s_axis_tuser),
				                                         s_axis_tdata[7:0], s_axis_tdata[23:8]));
		end
		pending = expected_replies.size();
	end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives pool requests and capacity settings into the buffer pool with random
// gaps and reply back-pressure, including one long reply stall, and leaves the
// checking to the monitor beside the block.
// ----------------------------------------------------------------------------
module testbench;
	import lbp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 78;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;    // file_number[7:0], block_number[23:8]
	logic [1:0]  s_axis_tuser = '0;    // cmd[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // slot[3:0], evicted_valid[4],
	                                   // evicted_file[12:5], evicted_block[28:13]
	logic [2:0]  m_axis_tuser;         // status[2:0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;        // capacity[4:0]

	int mismatches;
	int pending;
	int quiet_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lru_buffer_pool_with_pins i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	lru_pool_monitor i_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// Valid stays high on return so that a following call can keep it up.
	task automatic issue(cmd_t op, logic [7:0] f, logic [15:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, f};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Write only with the pool idle: drain all replies, then let the pipeline settle.
	task automatic set_capacity(logic [4:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				stall = calm ? 0 : $urandom_range(0, 11);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		logic [4:0]  cap_plan [12];
		logic [7:0]  fbase;
		logic [15:0] bbase;
		logic [7:0]  f;
		logic [15:0] b;
		cmd_t        op;
		int          pick;

		cap_plan = '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8,
		             5'd17, 5'd2, 5'd12, 5'd4, 5'd16, 5'd6};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset capacity: loads, hit, pin and unpin on present and absent blocks
		issue(CMD_ACCESS, 8'h00, 16'h0000);
		issue(CMD_ACCESS, 8'hFF, 16'hFFFF);
		issue(CMD_ACCESS, 8'h00, 16'h0000);
		issue(CMD_PIN,    8'hFF, 16'hFFFF);
		issue(CMD_PIN,    8'h12, 16'h3456);
		issue(CMD_UNPIN,  8'hFF, 16'hFFFF);
		issue(CMD_UNPIN,  8'hA5, 16'h5AA5);
		issue(CMD_CLEAR,  8'h5A, 16'hA55A);

		// two slots, both pinned: refuse, then evict once one is released
		set_capacity(5'd2);
		issue(CMD_ACCESS, 8'h01, 16'h0001);
		issue(CMD_ACCESS, 8'h01, 16'h0002);
		issue(CMD_PIN,    8'h01, 16'h0001);
		issue(CMD_PIN,    8'h01, 16'h0002);
		issue(CMD_ACCESS, 8'h01, 16'h0003);
		issue(CMD_UNPIN,  8'h01, 16'h0001);
		issue(CMD_ACCESS, 8'h01, 16'h0003);
		issue(CMD_CLEAR,  8'h00, 16'h0000);

		// zero acts as one slot
		set_capacity(5'd0);
		issue(CMD_ACCESS, 8'h02, 16'h0001);
		issue(CMD_ACCESS, 8'h02, 16'h0002);

		// no clear between phases, so a lower capacity often meets a fuller pool
		for (int phase = 0; phase < 12; phase++) begin
			set_capacity(cap_plan[phase]);
			calm = (phase % 4 == 1);
			if (phase == 5)
				hold_req = 1'b1;
			fbase = 8'($urandom_range(0, 252));
			bbase = 16'($urandom_range(0, 65528));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				op = (pick < 60) ? CMD_ACCESS : (pick < 78) ? CMD_PIN :
				     (pick < 98) ? CMD_UNPIN : CMD_CLEAR;
				if ($urandom_range(0, 19) == 0) begin
					f = 8'($urandom);
					b = 16'($urandom);
				end else begin
					f = fbase + 8'($urandom_range(0, 3));
					b = bbase + 16'($urandom_range(0, 7));
				end
				issue(op, f, b);
			end
		end

		s_axis_tvalid <= 1'b0;
		calm = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[lru_buffer_pool_with_pins.f]
+incdir+sv
sv/lbp_pkg.sv
sv/lbp_ctrl.sv
sv/lbp_dpath.sv
sv/lru_buffer_pool_with_pins.sv
tb/lru_pool_monitor.sv
tb/testbench.sv
